// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/ipt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipt_pkg
// Types and constants of the IR pulse train transmitter.
// ----------------------------------------------------------------------------
package ipt_pkg;

   localparam int TABLE_DEPTH_DEFAULT   = 32;
   localparam int DURATION_BITS_DEFAULT = 16;

   localparam int KIND_BITS            = 2;
   localparam int ENTRY_INDEX_BITS     = 5;
   localparam int RAW_DURATION_BITS    = 14;

   localparam int SEQUENCE_LENGTH_BITS = 6;
   localparam int REPEAT_COUNT_BITS    = 4;
   localparam int HALF_PERIOD_BITS     = 8;
   localparam int TICKS_PER_UNIT_BITS  = 8;

   localparam int CSR_INDEX_BITS       = 2;
   localparam int CSR_DATA_BITS        = 8;

   // duration scaling: q = (operand * recip) >> RECIP_SHIFT
   localparam int OPERAND_BITS = RAW_DURATION_BITS + 1;
   localparam int RECIP_BITS   = 22;
   localparam int RECIP_SHIFT  = 20;
   localparam int PROD_BITS    = OPERAND_BITS + RECIP_BITS;
   localparam int QUOT_BITS    = PROD_BITS - RECIP_SHIFT;
   // 2.7 and 2/19 in 2^-20 units, rounded up
   localparam logic [RECIP_BITS-1:0] MARK_RECIP  = 22'd2831156;
   localparam logic [RECIP_BITS-1:0] SPACE_RECIP = 22'd110377;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_WRITE = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SEQUENCE_LENGTH     = 2'd0,
      CSR_REPEAT_COUNT        = 2'd1,
      CSR_CARRIER_HALF_PERIOD = 2'd2,
      CSR_TICKS_PER_UNIT      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SEQUENCE_LENGTH_BITS-1:0] sequence_length;
      logic [REPEAT_COUNT_BITS-1:0]    repeat_count;
      logic [HALF_PERIOD_BITS-1:0]     carrier_half_period;
      logic [TICKS_PER_UNIT_BITS-1:0]  ticks_per_unit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      sequence_length:     6'd24,
      repeat_count:        4'd5,
      carrier_half_period: 8'd14,
      ticks_per_unit:      8'd10
   };

   typedef struct packed {
      logic led_on;
      logic busy_res;
      logic done_res;
   } result_type;

endpackage

// ----- src/ipt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipt_req_if / ipt_rsp_if
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface ipt_req_if import ipt_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [KIND_BITS-1:0]         kind;
   logic [ENTRY_INDEX_BITS-1:0]  entry_index;
   logic [RAW_DURATION_BITS-1:0] raw_duration;

   modport source (output valid, output kind, output entry_index, output raw_duration,
                   input ready);
   modport sink   (input valid, input kind, input entry_index, input raw_duration,
                   output ready);
endinterface

interface ipt_rsp_if ();
   logic valid;
   logic ready;
   logic led_on;
   logic busy_res;
   logic done_res;

   modport source (output valid, output led_on, output busy_res, output done_res,
                   input ready);
   modport sink   (input valid, input led_on, input busy_res, input done_res,
                   output ready);
endinterface

// ----- src/ipt_scaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipt_scaler
// Scales a raw table write: marks by 2.7 of (raw+1), spaces by 2/19 of raw.
// ----------------------------------------------------------------------------
module ipt_scaler import ipt_pkg::*; #(
   parameter int DURATION_BITS = DURATION_BITS_DEFAULT
) (
   input  logic [RAW_DURATION_BITS-1:0] raw_duration,
   input  logic                         is_space,
   output logic [DURATION_BITS-1:0]     duration,
   output logic                         duration_zero
);

   localparam int WIDE_BITS = (DURATION_BITS > QUOT_BITS) ? DURATION_BITS : QUOT_BITS;

   logic [OPERAND_BITS-1:0] operand;
   logic [RECIP_BITS-1:0]   recip;
   logic [PROD_BITS-1:0]    product;
   logic [QUOT_BITS-1:0]    quotient;
   logic [WIDE_BITS-1:0]    quot_wide;
   logic [WIDE_BITS-1:0]    dur_max_wide;

   assign operand  = is_space ? OPERAND_BITS'(raw_duration)
                              : OPERAND_BITS'(raw_duration) + OPERAND_BITS'(1);
   assign recip    = is_space ? SPACE_RECIP : MARK_RECIP;
   assign product  = PROD_BITS'(operand) * PROD_BITS'(recip);
   assign quotient = product[PROD_BITS-1:RECIP_SHIFT];

   assign quot_wide    = WIDE_BITS'(quotient);
   assign dur_max_wide = WIDE_BITS'({DURATION_BITS{1'b1}});
   assign duration     = (quot_wide > dur_max_wide) ? {DURATION_BITS{1'b1}}
                                                    : DURATION_BITS'(quot_wide);
   assign duration_zero = (quotient == '0);

endmodule

// ----- src/ipt_player.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipt_player
// Duration table memory and the burst sequencer that plays it.
// ----------------------------------------------------------------------------
module ipt_player import ipt_pkg::*; #(
   parameter int TABLE_DEPTH   = TABLE_DEPTH_DEFAULT,
   parameter int DURATION_BITS = DURATION_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        item_accept,
   input  logic [KIND_BITS-1:0]        item_kind,
   input  logic [ENTRY_INDEX_BITS-1:0] item_index,
   input  logic [DURATION_BITS-1:0]    item_duration,
   input  logic                        item_duration_zero,
   output result_type                  result
);

   localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int LEN_CAP   = (TABLE_DEPTH / 2) * 2;
   localparam int CMP_BITS  = ((ADDR_BITS > SEQUENCE_LENGTH_BITS) ? ADDR_BITS
                                                                  : SEQUENCE_LENGTH_BITS) + 2;

   logic [DURATION_BITS-1:0] dur_mem_ff [TABLE_DEPTH];
   logic [DURATION_BITS-1:0] rdata_ff;
   logic [TABLE_DEPTH-1:0]   zero_ff;

   logic                         playing_ff, playing_in;
   logic [ADDR_BITS-1:0]         pos_ff, pos_in;
   logic [REPEAT_COUNT_BITS-1:0] reps_ff, reps_in;
   logic [DURATION_BITS-1:0]     units_ff, units_in;
   logic [TICKS_PER_UNIT_BITS-1:0] presc_ff, presc_in;
   logic [HALF_PERIOD_BITS-1:0]  cc_ff, cc_in;
   logic                         level_ff, level_in;
   logic                         pend_ff, pend_in;

   logic                         rd_en;
   logic [ADDR_BITS-1:0]         rd_addr;
   logic                         mem_we;
   logic                         index_ok;
   logic [ADDR_BITS-1:0]         wr_addr;

   logic [SEQUENCE_LENGTH_BITS-1:0] seq_even;
   logic [SEQUENCE_LENGTH_BITS-1:0] play_len;
   logic [HALF_PERIOD_BITS-1:0]     half;
   logic [TICKS_PER_UNIT_BITS-1:0]  tpu;
   logic                            start_ok;
   logic                            drive;
   logic                            is_mark;

   logic [DURATION_BITS-1:0]       units_cur;
   logic [HALF_PERIOD_BITS:0]      cc_inc;
   logic                           cc_wrap;
   logic [HALF_PERIOD_BITS-1:0]    cc_tick;
   logic                           level_tick;
   logic [TICKS_PER_UNIT_BITS:0]   presc_inc;
   logic                           presc_wrap;
   logic [TICKS_PER_UNIT_BITS-1:0] presc_tick;
   logic [DURATION_BITS-1:0]       units_tick;

   logic [CMP_BITS-1:0]          n1, n2, len_cmp;
   logic                         n1_zero;
   logic                         adv_wrap;
   logic [ADDR_BITS-1:0]         adv_pos;
   logic [REPEAT_COUNT_BITS-1:0] reps_next;
   logic                         burst_end;

   assign seq_even = {cfg.sequence_length[SEQUENCE_LENGTH_BITS-1:1], 1'b0};
   assign play_len = (int'(seq_even) > LEN_CAP) ? SEQUENCE_LENGTH_BITS'(LEN_CAP) : seq_even;
   assign half     = (cfg.carrier_half_period == '0) ? HALF_PERIOD_BITS'(1)
                                                     : cfg.carrier_half_period;
   assign tpu      = (cfg.ticks_per_unit == '0) ? TICKS_PER_UNIT_BITS'(1)
                                                : cfg.ticks_per_unit;
   assign start_ok = !playing_ff && (play_len >= SEQUENCE_LENGTH_BITS'(2))
                     && (cfg.repeat_count != '0);
   assign is_mark  = ~pos_ff[0];
   assign drive    = playing_ff & is_mark & level_ff;

   assign index_ok = int'(item_index) < TABLE_DEPTH;
   assign wr_addr  = ADDR_BITS'(item_index);

   // element loaded last cycle arrives from the read register
   assign units_cur = pend_ff ? rdata_ff : units_ff;

   // carrier and unit prescaler for one tick
   assign cc_inc     = {1'b0, cc_ff} + (HALF_PERIOD_BITS + 1)'(1);
   assign cc_wrap    = cc_inc >= {1'b0, half};
   assign cc_tick    = !is_mark ? cc_ff : (cc_wrap ? '0 : cc_inc[HALF_PERIOD_BITS-1:0]);
   assign level_tick = (is_mark && cc_wrap) ? ~level_ff : level_ff;
   assign presc_inc  = {1'b0, presc_ff} + (TICKS_PER_UNIT_BITS + 1)'(1);
   assign presc_wrap = presc_inc >= {1'b0, tpu};
   assign presc_tick = presc_wrap ? '0 : presc_inc[TICKS_PER_UNIT_BITS-1:0];
   assign units_tick = (presc_wrap && units_cur != '0) ? units_cur - DURATION_BITS'(1)
                                                      : units_cur;

   // next element; marks are never empty, so at most one empty space is skipped
   assign n1      = CMP_BITS'(pos_ff) + CMP_BITS'(1);
   assign n2      = CMP_BITS'(pos_ff) + CMP_BITS'(2);
   assign len_cmp = CMP_BITS'(play_len);
   assign n1_zero = n1[0] && zero_ff[ADDR_BITS'(n1)];

   always_comb begin
      adv_wrap = 1'b0;
      adv_pos  = '0;
      if (n1 < len_cmp) begin
         if (n1_zero) begin
            if (n2 < len_cmp) begin
               adv_pos = ADDR_BITS'(n2);
            end else begin
               adv_wrap = 1'b1;
            end
         end else begin
            adv_pos = ADDR_BITS'(n1);
         end
      end else begin
         adv_wrap = 1'b1;
      end
   end

   assign reps_next = reps_ff + REPEAT_COUNT_BITS'(1);
   assign burst_end = adv_wrap && ((reps_next >= cfg.repeat_count) || (reps_next == '0));

   always_comb begin
      playing_in = playing_ff;
      pos_in     = pos_ff;
      reps_in    = reps_ff;
      units_in   = units_cur;
      presc_in   = presc_ff;
      cc_in      = cc_ff;
      level_in   = level_ff;
      pend_in    = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = pos_ff;
      mem_we     = 1'b0;
      result.led_on   = drive;
      result.busy_res = playing_ff;
      result.done_res = 1'b0;
      if (item_accept) begin
         unique case (item_kind)
            KIND_TICK: begin
               if (playing_ff) begin
                  if (units_tick == '0) begin
                     if (adv_wrap) begin
                        reps_in = reps_next;
                     end
                     if (burst_end) begin
                        playing_in = 1'b0;
                        pos_in     = '0;
                        units_in   = '0;
                        presc_in   = '0;
                        cc_in      = '0;
                        level_in   = 1'b0;
                        result.done_res = 1'b1;
                     end else begin
                        pos_in   = adv_pos;
                        presc_in = '0;
                        cc_in    = '0;
                        level_in = ~adv_pos[0];
                        rd_en    = 1'b1;
                        rd_addr  = adv_pos;
                        pend_in  = 1'b1;
                     end
                  end else begin
                     units_in = units_tick;
                     presc_in = presc_tick;
                     cc_in    = cc_tick;
                     level_in = level_tick;
                  end
               end
            end
            KIND_START: begin
               if (start_ok) begin
                  playing_in = 1'b1;
                  pos_in     = '0;
                  reps_in    = '0;
                  presc_in   = '0;
                  cc_in      = '0;
                  level_in   = 1'b1;
                  rd_en      = 1'b1;
                  rd_addr    = '0;
                  pend_in    = 1'b1;
                  result.led_on   = 1'b1;
                  result.busy_res = 1'b1;
               end
            end
            KIND_WRITE: begin
               mem_we = index_ok;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff <= 1'b0;
         pos_ff     <= '0;
         reps_ff    <= '0;
         units_ff   <= '0;
         presc_ff   <= '0;
         cc_ff      <= '0;
         level_ff   <= 1'b0;
         pend_ff    <= 1'b0;
         zero_ff    <= '0;
      end else begin
         playing_ff <= playing_in;
         pos_ff     <= pos_in;
         reps_ff    <= reps_in;
         units_ff   <= units_in;
         presc_ff   <= presc_in;
         cc_ff      <= cc_in;
         level_ff   <= level_in;
         pend_ff    <= pend_in;
         if (mem_we) begin
            zero_ff[wr_addr] <= item_duration_zero;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         dur_mem_ff[wr_addr] <= item_duration;
      end
      if (rd_en) begin
         rdata_ff <= dur_mem_ff[rd_addr];
      end
   end

endmodule

// ----- src/ipt_rsp_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipt_rsp_buf
// Two-word response buffer between the sequencer and the response channel.
// ----------------------------------------------------------------------------
module ipt_rsp_buf import ipt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_word,
   input  logic       pop_ready,
   output logic       can_push,
   output logic       out_valid,
   output result_type out_word
);

   result_type slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign can_push  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && pop_ready;

   always_comb begin
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- src/ir_pulse_train_transmitter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_train_transmitter_core
// Plays a stored IR code as carrier-modulated marks and unlit spaces.
// ----------------------------------------------------------------------------
// Takes one request word per clock cycle when ready and returns one response
// word per request, registered, from the cycle after acceptance. Ticks, starts
// and table writes may follow each other back to back: the duration table is
// a single-port-write, single-port-read memory, and the entry of the next mark
// or space is read in the cycle that ends the current one, its data taking
// over the unit counter in the following cycle. Empty spaces are skipped
// within the same tick. A two-word response buffer keeps requests flowing
// for one word while the response side stalls. The table needs no clearing
// after reset; entries must be written before they are played. Registers
// are to be written by the user through the csr port while the block is idle.
module ir_pulse_train_transmitter_core import ipt_pkg::*; #(
   parameter int TABLE_DEPTH   = TABLE_DEPTH_DEFAULT,
   parameter int DURATION_BITS = DURATION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   ipt_req_if.sink                   req,
   ipt_rsp_if.source                 rsp,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   cfg_type                  cfg_ff, cfg_in;
   logic                     req_accept;
   logic                     can_push;
   logic [DURATION_BITS-1:0] scaled_duration;
   logic                     scaled_zero;
   result_type               result;
   result_type               out_word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SEQUENCE_LENGTH:
               cfg_in.sequence_length = csr_write_data[SEQUENCE_LENGTH_BITS-1:0];
            CSR_REPEAT_COUNT:
               cfg_in.repeat_count = csr_write_data[REPEAT_COUNT_BITS-1:0];
            CSR_CARRIER_HALF_PERIOD:
               cfg_in.carrier_half_period = csr_write_data[HALF_PERIOD_BITS-1:0];
            CSR_TICKS_PER_UNIT:
               cfg_in.ticks_per_unit = csr_write_data[TICKS_PER_UNIT_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req.ready  = can_push;
   assign req_accept = req.valid && can_push;

   ipt_scaler #(
      .DURATION_BITS (DURATION_BITS)
   ) u_scaler (
      .raw_duration  (req.raw_duration),
      .is_space      (req.entry_index[0]),
      .duration      (scaled_duration),
      .duration_zero (scaled_zero)
   );

   ipt_player #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .DURATION_BITS (DURATION_BITS)
   ) u_player (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .item_accept        (req_accept),
      .item_kind          (req.kind),
      .item_index         (req.entry_index),
      .item_duration      (scaled_duration),
      .item_duration_zero (scaled_zero),
      .result             (result)
   );

   ipt_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_word (result),
      .pop_ready (rsp.ready),
      .can_push  (can_push),
      .out_valid (rsp.valid),
      .out_word  (out_word)
   );

   assign rsp.led_on   = out_word.led_on;
   assign rsp.busy_res = out_word.busy_res;
   assign rsp.done_res = out_word.done_res;

endmodule

// ----- src/ipt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipt_checker
// Port-level checks of the transmitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_led_on,
   input logic rsp_busy_res,
   input logic rsp_done_res
);

   logic [1:0] pending_ff, pending_in;

   // words accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_led_on) && $stable(rsp_busy_res) && $stable(rsp_done_res))
   `ASSERT_IMPLIES(a_rsp_has_req, clock, reset, rsp_valid, pending_ff != 2'd0)
   `ASSERT_IMPLIES(a_stall_only_full, clock, reset, !req_ready, pending_ff == 2'd2)
   `ASSERT_IMPLIES(a_done_busy, clock, reset, rsp_valid && rsp_done_res, rsp_busy_res)
   `ASSERT_IMPLIES(a_led_busy, clock, reset, rsp_valid && rsp_led_on, rsp_busy_res)

endmodule

bind ir_pulse_train_transmitter_core ipt_checker u_ipt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_led_on   (rsp.led_on),
   .rsp_busy_res (rsp.busy_res),
   .rsp_done_res (rsp.done_res)
);

// ----- tb/sv/ipt_transmit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipt_transmit_checker
// Watches the request, response and csr ports of the IR pulse train
// transmitter, tracks the burst state of the block request by request in
// its own terms and compares every response word with the predicted emitter,
// busy and done levels, oldest first.
// ----------------------------------------------------------------------------
module ipt_transmit_checker import ipt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   ipt_req_if                        req,
   ipt_rsp_if                        rsp,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output int unsigned               mismatch_count,
   output int unsigned               words_in_flight
);

   localparam int unsigned SPAN_MAX = (1 << DURATION_BITS_DEFAULT) - 1;

   logic [DURATION_BITS_DEFAULT-1:0] span_table [TABLE_DEPTH_DEFAULT];
   cfg_type                          live_cfg = CFG_RESET;
   bit                               running = 1'b0;
   logic [5:0]                       slot = '0;
   logic [REPEAT_COUNT_BITS-1:0]     laps = '0;
   logic [DURATION_BITS_DEFAULT-1:0] units_togo = '0;
   logic [TICKS_PER_UNIT_BITS-1:0]   unit_div = '0;
   logic [HALF_PERIOD_BITS-1:0]      carrier_div = '0;
   logic                             carrier_on = 1'b0;
   result_type                       led_trace [$];
   result_type                       want;
   int unsigned                      word_seq = 0;

   initial begin
      mismatch_count  = 0;
      words_in_flight = 0;
   end

   task automatic report_mismatch(string field, logic got, logic wanted);
      $display("word %0d: %s is %b, predicted %b", word_seq, field, got, wanted);
      mismatch_count++;
   endtask

   function automatic int unsigned code_length();
      int unsigned n;
      n = 32'(live_cfg.sequence_length & 6'h3E);
      return (n > (TABLE_DEPTH_DEFAULT & ~1)) ? (TABLE_DEPTH_DEFAULT & ~1) : n;
   endfunction

   function automatic void load_slot();
      units_togo  = span_table[slot[4:0]];
      unit_div    = '0;
      carrier_div = '0;
      carrier_on  = ~slot[0];
   endfunction

   // skips finished and empty entries; 1 when the burst is over
   function automatic bit next_slot();
      forever begin
         slot = slot + 6'd1;
         if (slot >= code_length()) begin
            slot = '0;
            laps = laps + 4'd1;
            if (laps >= live_cfg.repeat_count || laps == '0) begin
               running     = 1'b0;
               units_togo  = '0;
               unit_div    = '0;
               carrier_div = '0;
               carrier_on  = 1'b0;
               return 1'b1;
            end
         end
         load_slot();
         if (units_togo != '0) return 1'b0;
      end
   endfunction

   function automatic logic emitter_level();
      return running && !slot[0] && carrier_on;
   endfunction

   function automatic result_type transmit_word(logic [KIND_BITS-1:0] kind,
                                                logic [ENTRY_INDEX_BITS-1:0] idx,
                                                logic [RAW_DURATION_BITS-1:0] raw);
      result_type  r;
      int unsigned half;
      int unsigned tpu;
      int unsigned scaled;
      r = '0;
      case (kind)
         KIND_TICK: begin
            if (running) begin
               half = (live_cfg.carrier_half_period == '0) ? 1 : live_cfg.carrier_half_period;
               tpu  = (live_cfg.ticks_per_unit == '0) ? 1 : live_cfg.ticks_per_unit;
               r.led_on   = emitter_level();
               r.busy_res = 1'b1;
               if (!slot[0]) begin
                  carrier_div = carrier_div + 8'd1;
                  if (carrier_div >= half) begin
                     carrier_div = '0;
                     carrier_on  = ~carrier_on;
                  end
               end
               unit_div = unit_div + 8'd1;
               if (unit_div >= tpu) begin
                  unit_div = '0;
                  if (units_togo != '0) units_togo = units_togo - 1'b1;
               end
               if (units_togo == '0 && next_slot()) r.done_res = 1'b1;
            end
         end
         KIND_START: begin
            if (!running && code_length() >= 2 && live_cfg.repeat_count != '0) begin
               running = 1'b1;
               slot    = '0;
               laps    = '0;
               load_slot();
               if (units_togo == '0 && next_slot()) r.done_res = 1'b1;
            end
            r.led_on   = emitter_level();
            r.busy_res = running;
         end
         KIND_WRITE: begin
            if (idx[0]) scaled = (raw * 2) / 19;
            else        scaled = ((raw + 1) * 27) / 10;
            span_table[idx] = DURATION_BITS_DEFAULT'((scaled > SPAN_MAX) ? SPAN_MAX : scaled);
            r.led_on   = emitter_level();
            r.busy_res = running;
         end
         default: begin
            r.led_on   = emitter_level();
            r.busy_res = running;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         live_cfg    = CFG_RESET;
         running     = 1'b0;
         slot        = '0;
         laps        = '0;
         units_togo  = '0;
         unit_div    = '0;
         carrier_div = '0;
         carrier_on  = 1'b0;
         led_trace.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SEQUENCE_LENGTH:
                  live_cfg.sequence_length = csr_write_data[SEQUENCE_LENGTH_BITS-1:0];
               CSR_REPEAT_COUNT:
                  live_cfg.repeat_count = csr_write_data[REPEAT_COUNT_BITS-1:0];
               CSR_CARRIER_HALF_PERIOD:
                  live_cfg.carrier_half_period = csr_write_data[HALF_PERIOD_BITS-1:0];
               CSR_TICKS_PER_UNIT:
                  live_cfg.ticks_per_unit = csr_write_data[TICKS_PER_UNIT_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (led_trace.size() == 0) begin
               report_mismatch("unrequested word valid", 1'b1, 1'b0);
            end else begin
               want = led_trace.pop_front();
               if (rsp.led_on !== want.led_on)
                  report_mismatch("led_on", rsp.led_on, want.led_on);
               if (rsp.busy_res !== want.busy_res)
                  report_mismatch("busy_res", rsp.busy_res, want.busy_res);
               if (rsp.done_res !== want.done_res)
                  report_mismatch("done_res", rsp.done_res, want.done_res);
            end
            word_seq++;
         end
         if (req.valid && req.ready)
            led_trace.push_back(transmit_word(req.kind, req.entry_index, req.raw_duration));
      end
      words_in_flight = led_trace.size();
   end

endmodule

// ----- tb/sv/tb_ir_pulse_train_transmitter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_pulse_train_transmitter_core
// Drives table writes, starts and ticks into the transmitter core under
// bursty request timing and a patterned response stall, reprograms the
// registers between phases once all words are back, and reports the verdict
// from the checker's mismatch count or a stuck-handshake timeout.
// ----------------------------------------------------------------------------
module tb_ir_pulse_train_transmitter_core;
   import ipt_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int STUCK_LIMIT  = 2000;
   localparam int WORD_TARGET  = 1650;
   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;
   int unsigned               mismatch_count;
   int unsigned               words_in_flight;
   int unsigned               items_sent = 0;
   int unsigned               burst_left = 0;
   int unsigned               stuck_cycles = 0;
   int unsigned               ready_left = 0;
   logic [7:0]                ready_mask = 8'hFF;
   logic [2:0]                ready_phase = '0;

   ipt_req_if req_bus ();
   ipt_rsp_if rsp_bus ();

   ir_pulse_train_transmitter_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   ipt_transmit_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .words_in_flight  (words_in_flight)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // response stall pattern, reshuffled per segment
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
         if (ready_mask == '0) ready_mask = 8'h01;
         ready_left = $urandom_range(16, 160);
      end else begin
         ready_left--;
      end
      rsp_bus.ready <= ready_mask[ready_phase];
      ready_phase   <= ready_phase + 3'd1;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   function automatic logic [RAW_DURATION_BITS-1:0] short_span(logic [ENTRY_INDEX_BITS-1:0] idx);
      return idx[0] ? RAW_DURATION_BITS'($urandom_range(0, 45))
                    : RAW_DURATION_BITS'($urandom_range(0, 3));
   endfunction

   function automatic cfg_type random_plan();
      cfg_type p;
      if ($urandom_range(0, 6) == 0) begin
         case ($urandom_range(0, 5))
            0:       p.sequence_length = 6'd0;
            1:       p.sequence_length = 6'd1;
            2:       p.sequence_length = 6'd2;
            3:       p.sequence_length = 6'd32;
            4:       p.sequence_length = 6'd33;
            default: p.sequence_length = 6'd63;
         endcase
      end else begin
         p.sequence_length = 6'($urandom_range(2, 10));
      end
      if ($urandom_range(0, 9) == 0)
         p.repeat_count = $urandom_range(0, 1) ? 4'd15 : 4'd0;
      else
         p.repeat_count = 4'($urandom_range(1, 3));
      case ($urandom_range(0, 29))
         0:       p.carrier_half_period = 8'd0;
         1:       p.carrier_half_period = 8'd1;
         2:       p.carrier_half_period = 8'd255;
         default: p.carrier_half_period = 8'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 29))
         0:       p.ticks_per_unit = 8'd0;
         1:       p.ticks_per_unit = 8'd1;
         2:       p.ticks_per_unit = 8'd255;
         default: p.ticks_per_unit = 8'($urandom_range(1, 3));
      endcase
      return p;
   endfunction

   // entered and left at a falling edge
   task automatic push_word(logic [KIND_BITS-1:0] kind, logic [ENTRY_INDEX_BITS-1:0] idx,
                            logic [RAW_DURATION_BITS-1:0] raw);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 20);
      end
      burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= kind;
      req_bus.entry_index  <= idx;
      req_bus.raw_duration <= raw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic tick_run(int unsigned n);
      repeat (n) push_word(KIND_TICK, ENTRY_INDEX_BITS'($urandom),
                           RAW_DURATION_BITS'($urandom));
   endtask

   task automatic drain_words();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (words_in_flight != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic program_registers(cfg_type plan, logic [3:0] pick);
      for (int r = 0; r < 4; r++) begin
         if (pick[r]) begin
            csr_write_enable <= 1'b1;
            csr_index        <= CSR_INDEX_BITS'(r);
            case (csr_index_type'(r))
               CSR_SEQUENCE_LENGTH:     csr_write_data <= CSR_DATA_BITS'(plan.sequence_length);
               CSR_REPEAT_COUNT:        csr_write_data <= CSR_DATA_BITS'(plan.repeat_count);
               CSR_CARRIER_HALF_PERIOD: csr_write_data <= plan.carrier_half_period;
               default:                 csr_write_data <= plan.ticks_per_unit;
            endcase
            @(negedge clock);
         end
      end
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int unsigned            phase_items;
      int unsigned            pick;
      logic [ENTRY_INDEX_BITS-1:0] idx;

      req_bus.valid        = 1'b0;
      req_bus.kind         = KIND_TICK;
      req_bus.entry_index  = '0;
      req_bus.raw_duration = '0;
      rsp_bus.ready        = 1'b0;
      csr_write_enable     = 1'b0;
      csr_index            = '0;
      csr_write_data       = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      program_registers('{sequence_length: 6'd2, repeat_count: 4'd1,
                          carrier_half_period: 8'd1, ticks_per_unit: 8'd1}, 4'hF);
      for (int e = 0; e < TABLE_DEPTH_DEFAULT; e++)
         push_word(KIND_WRITE, ENTRY_INDEX_BITS'(e), short_span(ENTRY_INDEX_BITS'(e)));
      push_word(KIND_WRITE, '1, '1);
      push_word(KIND_WRITE, '1, short_span('1));
      push_word(KIND_WRITE, '0, '0);
      push_word(KIND_WRITE, 5'd1, 14'd9);
      push_word(KIND_UNUSED, '1, '1);
      // shortest mark then empty space: done on the second tick
      push_word(KIND_START, '0, '0);
      tick_run(1);
      push_word(KIND_START, '1, '1);
      tick_run(2);

      drain_words();
      program_registers('{sequence_length: 6'd1, repeat_count: 4'd15,
                          carrier_half_period: 8'd0, ticks_per_unit: 8'd0}, 4'hF);
      push_word(KIND_START, '0, '0);
      tick_run(1);

      drain_words();
      program_registers('{sequence_length: 6'd6, repeat_count: 4'd0,
                          carrier_half_period: 8'd0, ticks_per_unit: 8'd0}, 4'h3);
      push_word(KIND_START, '0, '0);
      tick_run(1);

      drain_words();
      program_registers('{sequence_length: 6'd6, repeat_count: 4'd1,
                          carrier_half_period: 8'd0, ticks_per_unit: 8'd0}, 4'h2);
      push_word(KIND_START, '0, '0);
      tick_run(6);

      // reprogram mid-burst
      drain_words();
      program_registers('{sequence_length: 6'd63, repeat_count: 4'd1,
                          carrier_half_period: 8'd255, ticks_per_unit: 8'd255}, 4'hD);
      tick_run(4);
      drain_words();
      program_registers('{sequence_length: 6'd4, repeat_count: 4'd2,
                          carrier_half_period: 8'd2, ticks_per_unit: 8'd1}, 4'hF);
      tick_run(40);

      // longer mark and space
      push_word(KIND_WRITE, 5'd0, 14'd30);
      push_word(KIND_WRITE, 5'd1, 14'd400);
      drain_words();
      program_registers('{sequence_length: 6'd2, repeat_count: 4'd1,
                          carrier_half_period: 8'd3, ticks_per_unit: 8'd1}, 4'hF);
      tick_run(80);
      push_word(KIND_START, '0, '0);
      tick_run(140);
      push_word(KIND_WRITE, 5'd0, short_span(5'd0));
      push_word(KIND_WRITE, 5'd1, short_span(5'd1));

      while (items_sent < WORD_TARGET) begin
         drain_words();
         program_registers(random_plan(), 4'($urandom_range(1, 15)));
         phase_items = $urandom_range(20, 90);
         push_word(KIND_START, ENTRY_INDEX_BITS'($urandom), RAW_DURATION_BITS'($urandom));
         repeat (phase_items) begin
            pick = $urandom_range(0, 99);
            idx  = ENTRY_INDEX_BITS'($urandom);
            if (pick < 72) begin
               tick_run(1);
            end else if (pick < 82) begin
               push_word(KIND_START, idx, RAW_DURATION_BITS'($urandom));
            end else if (pick < 92) begin
               push_word(KIND_WRITE, idx, short_span(idx));
            end else if (pick < 96) begin
               // wide value overwritten before any tick can load it
               push_word(KIND_WRITE, idx, RAW_DURATION_BITS'($urandom));
               push_word(KIND_WRITE, idx, short_span(idx));
            end else begin
               push_word(KIND_UNUSED, idx, RAW_DURATION_BITS'($urandom));
            end
         end
      end

      drain_words();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
